// ===== design/ipd_pkg.sv =====
// shared constants, types and duration match function of the ir frame decoder
package ipd_pkg;

	localparam int DATA_BYTES_DEF  = 6;
	localparam int FRAME_DURATIONS = 100;
	localparam int POS_W           = 7;
	localparam logic [POS_W-1:0] POS_MAX = 7'd127;
	localparam int DATA_START      = 3;
	localparam int ADDR_W          = 5;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_COUNT     = 3'd1;
	localparam logic [2:0] ST_HDR_MARK  = 3'd2;
	localparam logic [2:0] ST_HDR_SPACE = 3'd3;
	localparam logic [2:0] ST_BIT       = 3'd4;
	localparam logic [2:0] ST_COMPL     = 3'd5;

	// register indexes
	localparam logic [2:0] REG_HDR_MARK  = 3'd0;
	localparam logic [2:0] REG_HDR_SPACE = 3'd1;
	localparam logic [2:0] REG_BIT_MARK  = 3'd2;
	localparam logic [2:0] REG_ONE_SPACE = 3'd3;
	localparam logic [2:0] REG_ZERO_SPACE= 3'd4;
	localparam logic [2:0] REG_REPEAT_GAP= 3'd5;
	localparam logic [2:0] REG_TOLERANCE = 3'd6;

	typedef struct packed {
		logic [15:0] header_mark_us;
		logic [15:0] header_space_us;
		logic [15:0] bit_mark_us;
		logic [15:0] one_space_us;
		logic [15:0] zero_space_us;
		logic [15:0] repeat_gap_us;
		logic [6:0]  tolerance_percent;
	} ipd_cfg_t;

	// frame state handed to the result stage on the last duration
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [2:0]       first_error;
		logic             repeat_seen;
	} ipd_snap_t;

	function automatic logic [23:0] times100(input logic [15:0] v);
		return 24'({v, 6'b0}) + 24'({v, 5'b0}) + 24'({v, 2'b0});
	endfunction

	// d within n*(100-t)/100 .. n*(100+t)/100, floors folded into the compares
	function automatic logic near_match(input logic [15:0] d, input logic [15:0] nom,
			input logic [6:0] tol);
		logic [22:0] nt;
		logic [23:0] n100;
		logic [23:0] d100;
		logic [23:0] lo_x;
		logic [23:0] hi_x;
		logic        lo_ok;
		logic        hi_ok;
		nt    = 23'(nom) * 23'(tol);
		n100  = times100(nom);
		d100  = times100(d);
		hi_x  = n100 + 24'(nt);
		lo_x  = n100 - 24'(nt);
		lo_ok = (tol >= 7'd100) || (lo_x <= d100 + 24'd99);
		hi_ok = d100 <= hi_x;
		return lo_ok && hi_ok;
	endfunction

endpackage

// ===== design/ipd_stream_if.sv =====
// handshake interfaces for duration beats in and result beats out
interface ipd_item_if;
	logic        valid;
	logic        ready;
	logic [15:0] duration_us;
	logic        frame_end;

	modport source(output valid, duration_us, frame_end, input ready);
	modport sink(input valid, duration_us, frame_end, output ready);
endinterface

interface ipd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        is_repeat;
	logic [23:0] code;

	modport source(output valid, status, is_repeat, code, input ready);
	modport sink(input valid, status, is_repeat, code, output ready);
endinterface

// ===== design/ir_pulse_distance_frame_decoder.sv =====
// top level of the infrared pulse-distance frame decoder
// Decodes one infrared frame from a stream of captured mark/space durations in
// microseconds, one duration per beat, with frame_end set on the last one. The
// first duration is the leading gap and sets is_repeat when it lies near
// repeat_gap_us; the next two must match the header mark and space; then come
// 8*DATA_BYTES bit pairs (a mark near bit_mark_us, then a space near
// one_space_us for a one or zero_space_us for a zero), shifted in MSB first.
// A match means the duration lies within tolerance_percent of its nominal
// value. On frame_end one result beat comes out: status 0 ok, 1 wrong count
// (not exactly 100 durations, counting saturates at 127), 2 header mark,
// 3 header space, 4 bad bit (the first of these in arrival order wins), or
// 5 when bytes 1, 3, 5 are not the complements of bytes 0, 2, 4; code holds
// bytes 4, 2, 0 and is zero unless the status is ok. Durations after the
// last data space are counted but not checked. The block takes one duration
// per clock cycle while input ready is high: each beat is checked in a single
// pass from its input register through one multiplier per compare (nominal
// times tolerance) against the frame state. A result passes from the input
// register through the snapshot register to the output register; input ready
// drops only when a result is waiting at the output, the snapshot stage behind
// it is full and the input register holds a last beat. Timing registers sit on
// an APB port at byte address 4*index and are to be changed only between
// frames.
module ir_pulse_distance_frame_decoder import ipd_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// duration beats in, result beats out
	ipd_item_if.sink          item,
	ipd_result_if.source      result,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ipd_cfg_t                cfg;
	logic                    snap_valid;
	logic                    snap_ready;
	ipd_snap_t               snap;
	logic [8*DATA_BYTES-1:0] snap_shift;

	// nominal timings and tolerance
	ipd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// per-beat checks and frame state; hands the final state on frame_end
	ipd_frame_track #(
		.DATA_BYTES (DATA_BYTES)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.snap_shift (snap_shift)
	);

	// status, complement check, code and output register
	ipd_result #(
		.DATA_BYTES (DATA_BYTES)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.snap_shift (snap_shift),
		.result     (result)
	);

endmodule

// ===== design/ipd_cfg_regs.sv =====
// apb register file holding nominal timings and tolerance
module ipd_cfg_regs import ipd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ipd_cfg_t          cfg
);

	ipd_cfg_t    cfg_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mark_us    <= 16'd4400;
			cfg_q.header_space_us   <= 16'd4400;
			cfg_q.bit_mark_us       <= 16'd550;
			cfg_q.one_space_us      <= 16'd1600;
			cfg_q.zero_space_us     <= 16'd550;
			cfg_q.repeat_gap_us     <= 16'd5000;
			cfg_q.tolerance_percent <= 7'd25;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HDR_MARK:   cfg_q.header_mark_us    <= pwdata[15:0];
				REG_HDR_SPACE:  cfg_q.header_space_us   <= pwdata[15:0];
				REG_BIT_MARK:   cfg_q.bit_mark_us       <= pwdata[15:0];
				REG_ONE_SPACE:  cfg_q.one_space_us      <= pwdata[15:0];
				REG_ZERO_SPACE: cfg_q.zero_space_us     <= pwdata[15:0];
				REG_REPEAT_GAP: cfg_q.repeat_gap_us     <= pwdata[15:0];
				REG_TOLERANCE:  cfg_q.tolerance_percent <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HDR_MARK:   prdata = 32'(cfg_q.header_mark_us);
			REG_HDR_SPACE:  prdata = 32'(cfg_q.header_space_us);
			REG_BIT_MARK:   prdata = 32'(cfg_q.bit_mark_us);
			REG_ONE_SPACE:  prdata = 32'(cfg_q.one_space_us);
			REG_ZERO_SPACE: prdata = 32'(cfg_q.zero_space_us);
			REG_REPEAT_GAP: prdata = 32'(cfg_q.repeat_gap_us);
			REG_TOLERANCE:  prdata = 32'(cfg_q.tolerance_percent);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== design/ipd_frame_track.sv =====
// input register, duration checks and per-frame state
module ipd_frame_track import ipd_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ipd_item_if.sink                item,
	input  ipd_cfg_t                cfg,
	output logic                    snap_valid,
	input  logic                    snap_ready,
	output ipd_snap_t               snap,
	output logic [8*DATA_BYTES-1:0] snap_shift
);

	localparam int SHIFT_W  = 8 * DATA_BYTES;
	localparam int DATA_END = DATA_START + 16 * DATA_BYTES;
	localparam logic [POS_W:0] DATA_START_P = (POS_W+1)'(DATA_START);
	localparam logic [POS_W:0] DATA_END_P   = (POS_W+1)'(DATA_END);

	logic               v_s1;
	logic [15:0]        dur_s1;
	logic               end_s1;
	logic               go_s1;

	logic [POS_W-1:0]   position_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [2:0]         err_q;
	logic               rep_q;

	logic [POS_W-1:0]   pos_n;
	logic [SHIFT_W-1:0] shift_n;
	logic [2:0]         err_n;
	logic               rep_n;

	logic [15:0]        nom_a;
	logic               match_a;
	logic               match_zero;
	logic               in_data;

	assign go_s1      = v_s1 && (!end_s1 || snap_ready);
	assign item.ready = !v_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			dur_s1 <= item.duration_us;
			end_s1 <= item.frame_end;
		end
	end

	// one nominal per position; data spaces also check the zero timing
	always_comb begin
		if (position_q == POS_W'(0))
			nom_a = cfg.repeat_gap_us;
		else if (position_q == POS_W'(1))
			nom_a = cfg.header_mark_us;
		else if (position_q == POS_W'(2))
			nom_a = cfg.header_space_us;
		else if (position_q[0])
			nom_a = cfg.bit_mark_us;
		else
			nom_a = cfg.one_space_us;
	end

	assign match_a    = near_match(dur_s1, nom_a, cfg.tolerance_percent);
	assign match_zero = near_match(dur_s1, cfg.zero_space_us, cfg.tolerance_percent);
	assign in_data    = ({1'b0, position_q} >= DATA_START_P) &&
		({1'b0, position_q} < DATA_END_P);

	always_comb begin
		pos_n   = position_q;
		shift_n = shift_q;
		err_n   = err_q;
		rep_n   = rep_q;
		if (position_q != POS_MAX) begin
			if (position_q == POS_W'(0)) begin
				rep_n = match_a;
			end else if (position_q == POS_W'(1)) begin
				if (!match_a && err_q == ST_OK)
					err_n = ST_HDR_MARK;
			end else if (position_q == POS_W'(2)) begin
				if (!match_a && err_q == ST_OK)
					err_n = ST_HDR_SPACE;
			end else if (in_data) begin
				if (position_q[0]) begin
					if (!match_a && err_q == ST_OK)
						err_n = ST_BIT;
				end else begin
					// one timing wins when both match
					shift_n = {shift_q[SHIFT_W-2:0], match_a};
					if (!match_a && !match_zero && err_q == ST_OK)
						err_n = ST_BIT;
				end
			end
			pos_n = position_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			shift_q    <= '0;
			err_q      <= ST_OK;
			rep_q      <= 1'b0;
		end else if (go_s1) begin
			if (end_s1) begin
				position_q <= '0;
				shift_q    <= '0;
				err_q      <= ST_OK;
				rep_q      <= 1'b0;
			end else begin
				position_q <= pos_n;
				shift_q    <= shift_n;
				err_q      <= err_n;
				rep_q      <= rep_n;
			end
		end
	end

	assign snap_valid       = v_s1 && end_s1;
	assign snap.position    = pos_n;
	assign snap.first_error = err_n;
	assign snap.repeat_seen = rep_n;
	assign snap_shift       = shift_n;

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && end_s1 |=> position_q == '0 && err_q == ST_OK)
		else $error("frame state not cleared after last beat");

	a_pos_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && !end_s1 && position_q == POS_MAX |=> position_q == POS_MAX)
		else $error("duration count left saturation");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && !end_s1 && err_q != ST_OK |=> err_q == $past(err_q))
		else $error("first error overwritten inside a frame");

endmodule

// ===== design/ipd_result.sv =====
// snapshot register, status and code build, output register
module ipd_result import ipd_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    snap_valid,
	output logic                    snap_ready,
	input  ipd_snap_t               snap,
	input  logic [8*DATA_BYTES-1:0] snap_shift,
	ipd_result_if.source            result
);

	localparam int SHIFT_W = 8 * DATA_BYTES;

	logic               v_s2;
	ipd_snap_t          snap_s2;
	logic [SHIFT_W-1:0] shift_s2;
	logic               go_s2;

	logic               out_v_q;
	logic [2:0]         status_q;
	logic               rep_q;
	logic [23:0]        code_q;

	logic [63:0]        pad;
	logic               compl_bad;
	logic [2:0]         status_n;
	logic [23:0]        code_n;

	assign go_s2      = v_s2 && (!out_v_q || result.ready);
	assign snap_ready = !v_s2 || go_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (snap_ready) begin
			v_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			snap_s2  <= snap;
			shift_s2 <= snap_shift;
		end
	end

	// byte 0 at the top; bytes past the data read as zero
	assign pad = 64'(shift_s2) << (64 - SHIFT_W);

	always_comb begin
		compl_bad = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (2 * k + 1 < DATA_BYTES) begin
				if (~pad[8*(7-2*k) +: 8] != pad[8*(6-2*k) +: 8])
					compl_bad = 1'b1;
			end
		end
	end

	always_comb begin
		if (snap_s2.position != POS_W'(FRAME_DURATIONS))
			status_n = ST_COUNT;
		else if (snap_s2.first_error != ST_OK)
			status_n = snap_s2.first_error;
		else if (compl_bad)
			status_n = ST_COMPL;
		else
			status_n = ST_OK;
	end

	assign code_n = (status_n == ST_OK) ? {pad[31:24], pad[47:40], pad[63:56]} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (go_s2) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			status_q <= status_n;
			rep_q    <= snap_s2.repeat_seen;
			code_q   <= code_n;
		end
	end

	assign result.valid     = out_v_q;
	assign result.status    = status_q;
	assign result.is_repeat = rep_q;
	assign result.code      = code_q;

	a_code_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_OK |-> result.code == '0)
		else $error("code given with a failing status");

	a_snap_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !go_s2 |=> v_s2 && $stable(snap_s2))
		else $error("pending frame snapshot lost");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the ir pulse-distance frame decoder
module tb_top import ipd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// no accepted beat or register access for this many cycles ends the run
	localparam int STALL_LIMIT = 3000;
	// cycles to let the result pipeline settle before a register write
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off that fills the result stages
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP = 30;

	// fault kinds that a well-formed frame can carry
	localparam int FLT_HDR_MARK  = 0;
	localparam int FLT_HDR_SPACE = 1;
	localparam int FLT_BIT_MARK  = 2;
	localparam int FLT_BIT_SPACE = 3;
	localparam int FLT_COMPL     = 4;

	typedef enum {FK_CLEAN, FK_FAULTY, FK_BAD_LEN, FK_NOISE} frame_kind_e;

	// frame decode prediction and comparison of result beats
	class frame_scoreboard;
		typedef struct {
			logic [2:0]  status;
			logic        is_repeat;
			logic [23:0] code;
		} verdict_t;

		verdict_t                    verdict_q[$];
		bit [15:0]                   nominal[6];
		bit [6:0]                    tol_pct;
		bit [6:0]                    pos;
		bit [8*DATA_BYTES_DEF-1:0]   shift_reg;
		bit [2:0]                    first_err;
		bit                          rep_seen;
		int                          errors;
		int                          frames_checked;
		int                          status_hits[8];
		int                          repeats;

		function new();
			nominal[REG_HDR_MARK]   = 16'd4400;
			nominal[REG_HDR_SPACE]  = 16'd4400;
			nominal[REG_BIT_MARK]   = 16'd550;
			nominal[REG_ONE_SPACE]  = 16'd1600;
			nominal[REG_ZERO_SPACE] = 16'd550;
			nominal[REG_REPEAT_GAP] = 16'd5000;
			tol_pct = 7'd25;
			clear_frame();
		endfunction

		function void clear_frame();
			pos       = '0;
			shift_reg = '0;
			first_err = ST_OK;
			rep_seen  = 1'b0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			if (idx == REG_TOLERANCE)
				tol_pct = val[6:0];
			else if (idx < REG_TOLERANCE)
				nominal[idx] = val[15:0];
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			if (idx == REG_TOLERANCE)
				return 32'(tol_pct);
			return 32'(nominal[idx]);
		endfunction

		// accepted range around a nominal duration, floors as integer division
		function void window(bit [15:0] n, output int unsigned lo, output int unsigned hi);
			int unsigned t;
			int unsigned nn;
			t  = tol_pct;
			nn = n;
			lo = (t >= 100) ? 0 : (nn * (100 - t)) / 100;
			hi = (nn * (100 + t)) / 100;
		endfunction

		function bit near_nominal(bit [15:0] d, bit [15:0] n);
			int unsigned lo;
			int unsigned hi;
			window(n, lo, hi);
			return (d >= lo) && (d <= hi);
		endfunction

		function bit [7:0] byte_of(int i);
			if (i >= DATA_BYTES_DEF)
				return 8'h00;
			return shift_reg[8*(DATA_BYTES_DEF-1-i) +: 8];
		endfunction

		function void flag(bit [2:0] st);
			if (first_err == ST_OK)
				first_err = st;
		endfunction

		function void note_duration(bit [15:0] d, bit last);
			int unsigned idx;
			int unsigned data_end;
			verdict_t    v;
			idx      = pos;
			data_end = DATA_START + 16 * DATA_BYTES_DEF;
			if (idx < POS_MAX) begin
				if (idx == 0) begin
					rep_seen = near_nominal(d, nominal[REG_REPEAT_GAP]);
				end else if (idx == 1) begin
					if (!near_nominal(d, nominal[REG_HDR_MARK]))
						flag(ST_HDR_MARK);
				end else if (idx == 2) begin
					if (!near_nominal(d, nominal[REG_HDR_SPACE]))
						flag(ST_HDR_SPACE);
				end else if (idx < data_end) begin
					if (((idx - DATA_START) & 1) == 0) begin
						if (!near_nominal(d, nominal[REG_BIT_MARK]))
							flag(ST_BIT);
					end else if (near_nominal(d, nominal[REG_ONE_SPACE])) begin
						shift_reg = (shift_reg << 1) | 1'b1;
					end else if (near_nominal(d, nominal[REG_ZERO_SPACE])) begin
						shift_reg = shift_reg << 1;
					end else begin
						shift_reg = shift_reg << 1;
						flag(ST_BIT);
					end
				end
				pos = 7'(idx + 1);
			end
			if (!last)
				return;
			if (pos != FRAME_DURATIONS) begin
				v.status = ST_COUNT;
			end else if (first_err != ST_OK) begin
				v.status = first_err;
			end else begin
				v.status = ST_OK;
				for (int i = 0; i + 1 < DATA_BYTES_DEF; i += 2) begin
					if (~byte_of(i) != byte_of(i + 1)) begin
						v.status = ST_COMPL;
						break;
					end
				end
			end
			v.is_repeat = rep_seen;
			v.code = (v.status == ST_OK) ? {byte_of(4), byte_of(2), byte_of(0)} : 24'h0;
			verdict_q.push_back(v);
			clear_frame();
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH @%0t: %s", $realtime, what);
		endtask

		task check_result(logic [2:0] st, logic rep, logic [23:0] code);
			verdict_t want;
			if (verdict_q.size() == 0) begin
				report($sformatf("unexpected result beat, status %0d", st));
				return;
			end
			want = verdict_q.pop_front();
			frames_checked++;
			if (st !== want.status)
				report($sformatf("status %0d, want %0d", st, want.status));
			if (rep !== want.is_repeat)
				report($sformatf("is_repeat %0b, want %0b", rep, want.is_repeat));
			if (code !== want.code)
				report($sformatf("code %06h, want %06h", code, want.code));
			status_hits[want.status]++;
			if (want.is_repeat)
				repeats++;
		endtask

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	ipd_item_if   item_ch();
	ipd_result_if res_ch();

	frame_scoreboard sb = new();

	// durations of the frame being sent
	bit [15:0] frame_q[$];
	int        beats_sent;
	int        frames_sent;
	// idle chance in percent of sender and receiver
	int        send_idle_pct;
	int        recv_idle_pct;
	// hold-off request, toggled by the stimulus, counted in the receiver
	logic      hold_go;
	int        hold_len;

	always #5 clk = ~clk;

	ir_pulse_distance_frame_decoder #(
		.DATA_BYTES(DATA_BYTES_DEF)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// receiver: random ready, or a long hold-off counted here
	initial begin : result_sink
		logic hold_seen;
		int   hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go !== hold_seen) begin
				hold_seen = hold_go;
				hold_left = hold_len;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// monitor: values sampled at the edge are the ones before it
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.status, res_ch.is_repeat, res_ch.code);
			if (item_ch.valid && item_ch.ready)
				sb.note_duration(item_ch.duration_us, item_ch.frame_end);
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
					(res_ch.valid && res_ch.ready) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("timeout: no beat for %0d cycles, %0d results outstanding",
			STALL_LIMIT, sb.pending());
		$display("Verification failed");
		$finish;
	end

	// register access: setup phase, access phase, then an idle phase
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] idx, output logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		val = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [2:0] idx);
		logic [31:0] got;
		reg_read(idx, got);
		if (got !== sb.reg_value(idx))
			sb.report($sformatf("register %0d reads %0h, want %0h", idx, got,
				sb.reg_value(idx)));
	endtask

	// one setting of all timing registers, each read back after its write
	task automatic program_timing(input bit [15:0] hm, input bit [15:0] hs,
			input bit [15:0] bm, input bit [15:0] one, input bit [15:0] zero,
			input bit [15:0] rep, input bit [6:0] tol);
		logic [31:0] vals[7];
		vals[REG_HDR_MARK]   = 32'(hm);
		vals[REG_HDR_SPACE]  = 32'(hs);
		vals[REG_BIT_MARK]   = 32'(bm);
		vals[REG_ONE_SPACE]  = 32'(one);
		vals[REG_ZERO_SPACE] = 32'(zero);
		vals[REG_REPEAT_GAP] = 32'(rep);
		vals[REG_TOLERANCE]  = 32'(tol);
		for (int i = 0; i < 7; i++) begin
			reg_write(3'(i), vals[i]);
			check_reg(3'(i));
		end
	endtask

	// one duration beat, with random idle cycles ahead of it
	task automatic send_beat(input bit [15:0] dur, input bit last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.duration_us <= dur;
		item_ch.frame_end   <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_beat(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
	endtask

	// sender pauses until every result is in, then the pipeline settles
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a duration inside the tolerance window of n
	function automatic bit [15:0] near_dur(bit [15:0] n);
		int unsigned lo;
		int unsigned hi;
		sb.window(n, lo, hi);
		if (hi > 65535)
			hi = 65535;
		return 16'($urandom_range(hi, lo));
	endfunction

	// a duration outside the window of n, where one exists
	function automatic bit [15:0] far_dur(bit [15:0] n);
		int unsigned lo;
		int unsigned hi;
		sb.window(n, lo, hi);
		if (lo == 0 && hi >= 65535)
			return 16'($urandom);
		if (hi >= 65535 || (lo > 0 && $urandom_range(1, 0) == 1))
			return 16'($urandom_range(lo - 1, 0));
		return 16'($urandom_range(65535, hi + 1));
	endfunction

	// a space that matches neither bit value, as far as the windows allow
	function automatic bit [15:0] bad_space();
		bit [15:0] d;
		d = 16'($urandom);
		for (int k = 0; k < 16; k++) begin
			d = $urandom_range(1, 0) ? far_dur(sb.nominal[REG_ONE_SPACE])
				: far_dur(sb.nominal[REG_ZERO_SPACE]);
			if (!sb.near_nominal(d, sb.nominal[REG_ONE_SPACE]) &&
					!sb.near_nominal(d, sb.nominal[REG_ZERO_SPACE]))
				break;
		end
		return d;
	endfunction

	function automatic frame_kind_e pick_kind();
		int r;
		r = $urandom_range(99, 0);
		if (r < 30)
			return FK_CLEAN;
		if (r < 55)
			return FK_FAULTY;
		if (r < 65)
			return FK_BAD_LEN;
		return FK_NOISE;
	endfunction

	// fills frame_q: a frame of the right shape with random content, or noise
	function automatic void build_frame(frame_kind_e kind);
		bit [7:0]  bytes[DATA_BYTES_DEF];
		bit [4:0]  faults;
		int        mark_fault_bit;
		int        space_fault_bit;
		int        target_len;
		bit        b;
		frame_q.delete();
		if (kind == FK_NOISE) begin
			// short garbage, sometimes made of plausible durations
			target_len = $urandom_range(12, 1);
			for (int i = 0; i < target_len; i++)
				frame_q.push_back($urandom_range(1, 0) ? 16'($urandom)
					: near_dur(sb.nominal[$urandom_range(5, 0)]));
			return;
		end
		faults = '0;
		if (kind == FK_FAULTY) begin
			// one fault, at times a second one to exercise error priority
			faults[$urandom_range(4, 0)] = 1'b1;
			if ($urandom_range(2, 0) == 0)
				faults[$urandom_range(4, 0)] = 1'b1;
		end
		mark_fault_bit  = $urandom_range(8 * DATA_BYTES_DEF - 1, 0);
		space_fault_bit = $urandom_range(8 * DATA_BYTES_DEF - 1, 0);
		// leading gap, repeat or not
		frame_q.push_back($urandom_range(1, 0) ? near_dur(sb.nominal[REG_REPEAT_GAP])
			: 16'($urandom));
		frame_q.push_back(faults[FLT_HDR_MARK] ? far_dur(sb.nominal[REG_HDR_MARK])
			: near_dur(sb.nominal[REG_HDR_MARK]));
		frame_q.push_back(faults[FLT_HDR_SPACE] ? far_dur(sb.nominal[REG_HDR_SPACE])
			: near_dur(sb.nominal[REG_HDR_SPACE]));
		// odd bytes complement the even bytes before them
		for (int i = 0; i < DATA_BYTES_DEF; i++)
			bytes[i] = (i % 2 == 0) ? 8'($urandom) : ~bytes[i - 1];
		if (faults[FLT_COMPL])
			bytes[$urandom_range(DATA_BYTES_DEF - 1, 0)] ^= 8'(1 << $urandom_range(7, 0));
		for (int i = 0; i < 8 * DATA_BYTES_DEF; i++) begin
			b = bytes[i / 8][7 - i % 8];
			frame_q.push_back((faults[FLT_BIT_MARK] && i == mark_fault_bit)
				? far_dur(sb.nominal[REG_BIT_MARK]) : near_dur(sb.nominal[REG_BIT_MARK]));
			if (faults[FLT_BIT_SPACE] && i == space_fault_bit)
				frame_q.push_back(bad_space());
			else
				frame_q.push_back(b ? near_dur(sb.nominal[REG_ONE_SPACE])
					: near_dur(sb.nominal[REG_ZERO_SPACE]));
		end
		// trailing mark is counted but never checked
		frame_q.push_back(16'($urandom));
		if (kind == FK_BAD_LEN) begin
			case ($urandom_range(2, 0))
				0: target_len = $urandom_range(FRAME_DURATIONS - 1, 1);
				1: target_len = $urandom_range(int'(POS_MAX) - 1, FRAME_DURATIONS + 1);
				// overlong: the count saturates
				default: target_len = $urandom_range(170, int'(POS_MAX) + 1);
			endcase
			while (frame_q.size() > target_len)
				void'(frame_q.pop_back());
			while (frame_q.size() < target_len)
				frame_q.push_back(16'($urandom));
		end
	endfunction

	task automatic run_phase(input int min_frames, input int min_beats);
		int frames;
		int start;
		frames = 0;
		start  = beats_sent;
		while (frames < min_frames || beats_sent - start < min_beats) begin
			build_frame(pick_kind());
			send_frame();
			frames++;
		end
	endtask

	// receiver holds off while the sender streams one-beat frames back to back
	task automatic back_pressure();
		int saved_pct;
		saved_pct     = send_idle_pct;
		send_idle_pct = 0;
		hold_len <= HOLD_CYCLES;
		hold_go  <= ~hold_go;
		for (int i = 0; i < 12; i++) begin
			frame_q = '{16'($urandom)};
			send_frame();
		end
		send_idle_pct = saved_pct;
	endtask

	initial begin : stimulus
		send_idle_pct = 29;
		recv_idle_pct = 65;
		beats_sent    = 0;
		frames_sent   = 0;
		hold_len      = 0;
		arst_n              <= 1'b0;
		hold_go             <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		item_ch.valid       <= 1'b0;
		item_ch.duration_us <= '0;
		item_ch.frame_end   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the timing registers
		for (int i = 0; i < 7; i++)
			check_reg(3'(i));

		// short frames: field extremes, count error ahead of header errors,
		// repeat gap at its window edges
		frame_q = '{16'd0};
		send_frame();
		frame_q = '{16'hFFFF};
		send_frame();
		frame_q = '{16'd5000, 16'd4400, 16'd4400};
		send_frame();
		frame_q = '{16'd0, 16'hFFFF, 16'd0, 16'd550, 16'd1600};
		send_frame();
		frame_q = '{16'd3750, 16'd3300, 16'd5500, 16'd687};
		send_frame();
		frame_q = '{16'd6250, 16'd3299, 16'd5501, 16'd412, 16'd2000, 16'd413};
		send_frame();
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			case (p)
				1: program_timing(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560,
					16'd2500, 7'd0);
				2: program_timing(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0,
					16'd0, 7'd99);
				// tolerance above 99: lower bounds vanish, one and zero overlap
				3: program_timing(16'd3000, 16'd1500, 16'd400, 16'd1200, 16'd400,
					16'hFFFF, 7'd127);
				4: program_timing(16'd4400, 16'd4400, 16'd550, 16'd800, 16'd600,
					16'd5000, 7'd50);
				5: program_timing(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom),
					7'($urandom_range(127, 0)));
				6: program_timing(16'd4400, 16'd4400, 16'd550, 16'd1600, 16'd550,
					16'd5000, 7'd10);
				default: ;
			endcase
			// idle pattern: sender light and receiver heavy, swapped, then none
			if (p < 2) begin
				send_idle_pct = 29;
				recv_idle_pct = 65;
			end else if (p < 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 2 || p == 5)
				back_pressure();
			run_phase(1, 65);
			wait_drained();
		end

		$display("covered %0d frames in %0d duration beats over 7 timing settings",
			frames_sent, beats_sent);
		$display("statuses ok/count/hmark/hspace/bit/compl: %0d/%0d/%0d/%0d/%0d/%0d, %0d repeats",
			sb.status_hits[ST_OK], sb.status_hits[ST_COUNT], sb.status_hits[ST_HDR_MARK],
			sb.status_hits[ST_HDR_SPACE], sb.status_hits[ST_BIT], sb.status_hits[ST_COMPL],
			sb.repeats);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
